// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RC frame decoder.
// Clocked by clock and disabled by reset of the enclosing module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rcfd_pkg.sv -----
// ---------------------------------------------------------------------------
// RC frame decoder package
// Shared constants and types for the frame front end, queue and decoder.
// ---------------------------------------------------------------------------
package rcfd_pkg;

   localparam int FRAME_LEN   = 18;
   localparam int COUNT_W     = 5;
   localparam int KEY_N       = 16;
   localparam int AXIS_W      = 11;
   localparam int DEADBAND_W  = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int RSP_W       = 144;

   localparam logic [COUNT_W-1:0]    COUNT_FULL     = COUNT_W'(FRAME_LEN);
   localparam logic [COUNT_W-1:0]    COUNT_OVER     = COUNT_W'(FRAME_LEN + 1);
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(20);

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } frame_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [4:0]               pad;
      logic [KEY_N-1:0]         keys_new_press;
      logic [KEY_N-1:0]         keys_held;
      logic [15:0]              mouse_buttons;
      logic signed [15:0]       mouse_y;
      logic signed [15:0]       mouse_x;
      logic [1:0]               switch_right;
      logic [1:0]               switch_left;
      logic signed [AXIS_W-1:0] dial_axis;
      logic signed [AXIS_W-1:0] left_stick_y;
      logic signed [AXIS_W-1:0] left_stick_x;
      logic signed [AXIS_W-1:0] right_stick_y;
      logic signed [AXIS_W-1:0] right_stick_x;
   } rsp_fields_type;

endpackage

// ----- sv/rc_receiver_frame_decoder.sv -----
// ---------------------------------------------------------------------------
// RC receiver frame decoder
// Byte-stream receiver for 18-byte remote-control frames.
// ---------------------------------------------------------------------------
// req_ carries one receiver byte per transfer, or an idle-line marker when
// req_tuser is set. Bytes are stored; the marker ends the frame and the
// frame is decoded only when exactly 18 bytes preceded it, otherwise it is
// dropped without a result and the key state stays as it was.
// rsp_ delivers one decoded frame per transfer: sticks and dial centred
// and deadbanded, switches, mouse, held keys and new key presses.
// csr_ writes the deadband (reset value 20); write only while idle.
// Throughput: one req_ transfer per cycle while req_tready is high. A good
// frame's result becomes valid once the marker transfer has passed through
// the frame queue and then the output register.
// A two-frame queue sits between the byte collector and the decoder, so
// bytes keep flowing while rsp_ stalls; req_tready drops only when that
// queue holds two frames not yet decoded.
// Reset empties the queue and output register, clears the byte count and
// all key press counters, and restores the deadband.
// ---------------------------------------------------------------------------
module rc_receiver_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // rx_byte
   input  logic                            req_tuser,  // idle_gap
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // right_stick_x, right_stick_y, left_stick_x, left_stick_y, dial_axis,
   // switch_left, switch_right, mouse_x, mouse_y, mouse_buttons,
   // keys_held, keys_new_press, zero fill
   output logic [rcfd_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                            csr_we,
   input  logic [rcfd_pkg::DEADBAND_W-1:0] csr_wdata
);
   import rcfd_pkg::*;

`include "assert_macros.svh"

   frame_push_type          push;
   frame_type               head;
   queue_status_type        q_status;
   logic                    pop;
   logic [DEADBAND_W-1:0]   deadband_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RESET;
      end else if (csr_we) begin
         deadband_ff <= csr_wdata;
      end
   end

   rcfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push)
   );

   rcfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   rcfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .deadband   (deadband_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_IMPLIES(a_no_push_when_full, push.valid, !q_status.full, "push into full queue")
   `ASSERT_IMPLIES(a_no_pop_when_empty, pop, !q_status.empty, "pop from empty queue")
   `ASSERT_NEXT(a_result_after_pop, pop, rsp_tvalid, "popped frame not presented")
   `ASSERT_IMPLIES(a_rsp_from_queue, $rose(rsp_tvalid), $past(pop), "result without pop")

endmodule

// ----- sv/rcfd_front.sv -----
// ---------------------------------------------------------------------------
// RC frame decoder front end
// Collects receiver bytes into the frame store and hands complete frames
// to the queue at the idle marker.
// ---------------------------------------------------------------------------
module rcfd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     req_tuser,
   input  rcfd_pkg::queue_status_type q_status,
   output rcfd_pkg::frame_push_type push
);
   import rcfd_pkg::*;

   frame_type          store_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               accept;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      priority if (!accept) begin
         count_in = count_ff;
      end else if (req_tuser) begin
         count_in = '0;
      end else if (count_ff < COUNT_OVER) begin
         count_in = count_ff + COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
         if (accept && !req_tuser && count_ff == COUNT_W'(i)) begin
            store_ff[i] <= req_tdata;
         end
      end
   end

   assign push.valid = accept && req_tuser && (count_ff == COUNT_FULL);
   assign push.frame = store_ff;

endmodule

// ----- sv/rcfd_queue.sv -----
// ---------------------------------------------------------------------------
// RC frame decoder frame queue
// Short queue of complete frames between the front end and the decoder.
// ---------------------------------------------------------------------------
module rcfd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  rcfd_pkg::frame_push_type   push,
   input  logic                       pop,
   output rcfd_pkg::frame_type        head,
   output rcfd_pkg::queue_status_type q_status
);
   import rcfd_pkg::*;

   frame_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QFILL_W-1:0] fill_ff;
   logic [QFILL_W-1:0] fill_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign q_status.full  = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign head           = mem_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push.valid, pop})
         2'b10:   fill_in = fill_ff + QFILL_W'(1);
         2'b01:   fill_in = fill_ff - QFILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push.valid) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.frame;
      end
   end

endmodule

// ----- sv/rcfd_back.sv -----
// ---------------------------------------------------------------------------
// RC frame decoder back end
// Unpacks a queued frame, applies the deadband, tracks key presses and
// holds the result in the output register.
// ---------------------------------------------------------------------------
module rcfd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  rcfd_pkg::frame_type               head,
   input  rcfd_pkg::queue_status_type        q_status,
   output logic                              pop,
   input  logic [rcfd_pkg::DEADBAND_W-1:0]   deadband,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rcfd_pkg::RSP_W-1:0]        rsp_tdata
);
   import rcfd_pkg::*;

   logic [1:0]       key_cnt_ff [KEY_N];
   logic [1:0]       key_cnt_in [KEY_N];
   logic [KEY_N-1:0] keys;
   logic [KEY_N-1:0] held;
   logic [KEY_N-1:0] fresh;
   rsp_fields_type   rsp_in;
   rsp_fields_type   rsp_ff;
   logic             rsp_valid_ff;

   // centre by flipping the top bit, then zero inside the deadband
   function automatic logic [AXIS_W-1:0] axis_value(input logic [AXIS_W-1:0] raw,
                                                    input logic [DEADBAND_W-1:0] db);
      logic [AXIS_W-1:0] v;
      logic [AXIS_W-1:0] mag;
      v   = {~raw[AXIS_W-1], raw[AXIS_W-2:0]};
      mag = v[AXIS_W-1] ? (~v + AXIS_W'(1)) : v;
      if (mag <= {1'b0, db}) begin
         return '0;
      end
      return v;
   endfunction

   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_tready);
   assign keys = {head[15], head[14]};

   always_comb begin
      for (int i = 0; i < KEY_N; i++) begin
         if (keys[i]) begin
            key_cnt_in[i] = (key_cnt_ff[i] < 2'd2) ? key_cnt_ff[i] + 2'd1 : key_cnt_ff[i];
         end else begin
            key_cnt_in[i] = 2'd0;
         end
         held[i]  = keys[i] && (key_cnt_in[i] >= 2'd2);
         fresh[i] = keys[i] && (key_cnt_in[i] < 2'd2);
      end
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.right_stick_x  = axis_value({head[1][2:0], head[0]}, deadband);
      rsp_in.right_stick_y  = axis_value({head[2][5:0], head[1][7:3]}, deadband);
      rsp_in.left_stick_x   = axis_value({head[4][0], head[3], head[2][7:6]}, deadband);
      rsp_in.left_stick_y   = axis_value({head[5][3:0], head[4][7:1]}, deadband);
      rsp_in.dial_axis      = axis_value({head[17][2:0], head[16]}, deadband);
      rsp_in.switch_left    = head[5][7:6];
      rsp_in.switch_right   = head[5][5:4];
      rsp_in.mouse_x        = {head[7], head[6]};
      rsp_in.mouse_y        = {head[9], head[8]};
      rsp_in.mouse_buttons  = {head[13], head[12]};
      rsp_in.keys_held      = held;
      rsp_in.keys_new_press = fresh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEY_N; i++) begin
            key_cnt_ff[i] <= 2'd0;
         end
      end else begin
         if (pop) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < KEY_N; i++) begin
               key_cnt_ff[i] <= key_cnt_in[i];
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule
